/* design/kdph_pkg.sv */
// Shared types, constants and helper functions for the keypad debounce block.
// No dependencies; every other file in the design folder but kdph_queue imports this package.
package kdph_pkg;

	// Key code: zero means no key, 1..12 are the matrix bit index plus one.
	typedef logic [3:0] key_code_t;

	// Time counters and configuration register values.
	typedef logic [15:0] ms_count_t;

	// ASCII code of a key, six bits wide.
	typedef logic [5:0] key_char_t;

	// Event kinds on the result channel.
	typedef enum logic {
		EV_PRESS = 1'b0,
		EV_HOLD  = 1'b1
	} event_kind_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_DEBOUNCE_MS = 1'b0,
		REG_HOLD_MS     = 1'b1
	} reg_index_t;

	// One result item as it travels through the result queue.
	typedef struct packed {
		event_kind_t event_kind;
		key_char_t   key_char;
	} kdph_result_t;

	localparam int unsigned MASK_W          = 12;
	localparam int unsigned CFG_DATA_W      = 16;
	localparam key_code_t   KEY_NONE        = 4'd0;
	localparam ms_count_t   DEBOUNCE_RESET  = 16'd15;
	localparam ms_count_t   HOLD_RESET      = 16'd300;
	localparam ms_count_t   COUNT_MAX       = 16'hFFFF;
	localparam int unsigned CODE_Q_DEPTH    = 2;
	localparam int unsigned RESULT_Q_DEPTH  = 2;

	// Lowest set bit of the snapshot, as a key code.
	function automatic key_code_t pick_key(input logic [MASK_W-1:0] mask);
		key_code_t code;
		code = KEY_NONE;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (mask[i]) begin
				code = key_code_t'(i + 1);
			end
		end
		return code;
	endfunction

	// Counter increment that sticks at the top value.
	function automatic ms_count_t sat_inc(input ms_count_t v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	// Key legend in row-major order: 1 2 3 / 4 5 6 / 7 8 9 / * 0 #.
	function automatic key_char_t char_of(input key_code_t code);
		key_char_t c;
		unique case (code)
			4'd1:    c = 6'(8'h31);
			4'd2:    c = 6'(8'h32);
			4'd3:    c = 6'(8'h33);
			4'd4:    c = 6'(8'h34);
			4'd5:    c = 6'(8'h35);
			4'd6:    c = 6'(8'h36);
			4'd7:    c = 6'(8'h37);
			4'd8:    c = 6'(8'h38);
			4'd9:    c = 6'(8'h39);
			4'd10:   c = 6'(8'h2A);
			4'd11:   c = 6'(8'h30);
			4'd12:   c = 6'(8'h23);
			default: c = 6'd0;
		endcase
		return c;
	endfunction

endpackage

/* design/keypad_debounce_press_hold_core.sv */
// Top level of the keypad debounce block with press and hold reporting.
// Depends on kdph_pkg, kdph_front, kdph_queue and kdph_back.
//
// Usage. Each transfer on the input side is one millisecond tick: the 12-bit
// pressed_mask snapshot of the 4x3 matrix, taken when push is high and full
// is low. Results leave like a queue: while empty is low, event_kind and
// key_char show the oldest event, taken when pop is high. PRESS is reported
// on a debounced release unless HOLD was already reported; HOLD once per press.
// Timing. One tick is accepted per cycle while full is low. The snapshot passes
// the front register, the code queue and the back state update; a result it
// causes is pushed into the result queue by that update. The rate is set by the
// back state update, which handles one tick a cycle while the result queue has room.
// Stalls. If pop stays low, the result queue fills and the back stops, then the
// code queue and front stage fill and full rises; nothing is lost.
// Reset. arst_n clears all tracking state and queues and loads debounce_ms
// with 15 and hold_ms with 300. Configuration is written through cfg_wen,
// cfg_idx (0 debounce_ms, 1 hold_ms) and cfg_wdata.
module keypad_debounce_press_hold_core #(
	parameter int unsigned CODE_Q_DEPTH   = kdph_pkg::CODE_Q_DEPTH,
	parameter int unsigned RESULT_Q_DEPTH = kdph_pkg::RESULT_Q_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  kdph_pkg::reg_index_t             cfg_idx,
	input  logic [kdph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             push,
	output logic                             full,
	input  logic [kdph_pkg::MASK_W-1:0]      pressed_mask,
	output logic                             empty,
	input  logic                             pop,
	output kdph_pkg::event_kind_t            event_kind,
	output kdph_pkg::key_char_t              key_char
);
	import kdph_pkg::*;

	logic         fr_valid;
	key_code_t    fr_code;
	logic         code_full;
	logic         code_empty;
	key_code_t    code_head;
	logic         code_pop;
	logic         res_full;
	logic         res_push;
	kdph_result_t res_in;
	kdph_result_t res_out;

	// Front part: snapshot to key code.
	kdph_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pressed_mask(pressed_mask),
		.full        (full),
		.code_valid  (fr_valid),
		.code        (fr_code),
		.code_full   (code_full)
	);

	// Queue between front and back.
	kdph_queue #(
		.WIDTH($bits(key_code_t)),
		.DEPTH(CODE_Q_DEPTH)
	) u_code_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_valid),
		.wdata (fr_code),
		.full  (code_full),
		.pop   (code_pop),
		.rdata (code_head),
		.empty (code_empty)
	);

	// Back part: debounce, hold tracking and event generation.
	kdph_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.code_empty (code_empty),
		.code       (code_head),
		.code_pop   (code_pop),
		.result_full(res_full),
		.result_push(res_push),
		.result     (res_in)
	);

	// Result queue facing the receiver.
	kdph_queue #(
		.WIDTH($bits(kdph_result_t)),
		.DEPTH(RESULT_Q_DEPTH)
	) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign event_kind = res_out.event_kind;
	assign key_char   = res_out.key_char;

endmodule

/* design/kdph_queue.sv */
// Small first-in first-out queue used between the front, the back and the result port.
// Depends on nothing but its parameters.
module kdph_queue #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage is written on every accepted transfer in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth; the count tracks the fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/kdph_front.sv */
// Front part: accepts matrix snapshots and reduces each to one key code.
// Depends on kdph_pkg.
module kdph_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [kdph_pkg::MASK_W-1:0]  pressed_mask,
	output logic                         full,
	output logic                         code_valid,
	output kdph_pkg::key_code_t          code,
	input  logic                         code_full
);
	import kdph_pkg::*;

	logic      valid_s1;
	key_code_t code_s1;
	logic      advance;

	// The stage moves on whenever it is empty or the code queue takes its content.
	assign advance    = !valid_s1 || !code_full;
	assign full       = !advance;
	assign code_valid = valid_s1;
	assign code       = code_s1;

	// Priority encoding happens on the way in, so the stage holds only the code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			code_s1 <= pick_key(pressed_mask);
		end
	end

endmodule

/* design/kdph_back.sv */
// Back part: debounce and hold tracking per tick, plus the configuration registers.
// Depends on kdph_pkg.
module kdph_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  kdph_pkg::reg_index_t             cfg_idx,
	input  logic [kdph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             code_empty,
	input  kdph_pkg::key_code_t              code,
	output logic                             code_pop,
	input  logic                             result_full,
	output logic                             result_push,
	output kdph_pkg::kdph_result_t           result
);
	import kdph_pkg::*;

	ms_count_t debounce_q;
	ms_count_t hold_ms_q;
	key_code_t cand_code_q;
	ms_count_t cand_age_q;
	key_code_t stable_code_q;
	key_code_t held_code_q;
	ms_count_t hold_age_q;
	logic      hold_done_q;

	key_code_t cand_code_d;
	ms_count_t cand_age_d;
	key_code_t stable_code_d;
	key_code_t held_code_d;
	ms_count_t hold_age_d;
	logic      hold_done_d;
	logic      ev_valid;
	event_kind_t ev_kind;
	key_code_t ev_code;
	logic      step;

	// A tick is processed only when one is waiting and the result queue has room, result or not.
	assign step        = !code_empty && !result_full;
	assign code_pop    = step;
	assign result_push = step && ev_valid;
	assign result.event_kind = ev_kind;
	assign result.key_char   = char_of(ev_code);

	// Next state for one tick.
	always_comb begin
		cand_code_d   = cand_code_q;
		cand_age_d    = cand_age_q;
		stable_code_d = stable_code_q;
		held_code_d   = held_code_q;
		hold_age_d    = hold_age_q;
		hold_done_d   = hold_done_q;
		ev_valid      = 1'b0;
		ev_kind       = EV_PRESS;
		ev_code       = held_code_q;

		if (held_code_q != KEY_NONE) begin
			hold_age_d = sat_inc(hold_age_q);
		end

		// The raw choice restarts its age whenever it changes.
		if (code != cand_code_q) begin
			cand_code_d = code;
			cand_age_d  = '0;
		end else begin
			cand_age_d = sat_inc(cand_age_q);
		end

		// Accept a debounced change: a new key starts hold tracking, a release reports.
		if (cand_age_d >= debounce_q && stable_code_q != cand_code_d) begin
			stable_code_d = cand_code_d;
			if (cand_code_d != KEY_NONE) begin
				held_code_d = cand_code_d;
				hold_age_d  = '0;
				hold_done_d = 1'b0;
			end else begin
				if (held_code_q != KEY_NONE && !hold_done_q) begin
					ev_valid = 1'b1;
					ev_kind  = EV_PRESS;
					ev_code  = held_code_q;
				end
				held_code_d = KEY_NONE;
			end
		end

		// Hold is reported once per press.
		if (held_code_d != KEY_NONE && !hold_done_d && hold_age_d >= hold_ms_q) begin
			ev_valid    = 1'b1;
			ev_kind     = EV_HOLD;
			ev_code     = held_code_d;
			hold_done_d = 1'b1;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_ms_q  <= HOLD_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_DEBOUNCE_MS: debounce_q <= cfg_wdata;
				REG_HOLD_MS:     hold_ms_q  <= cfg_wdata;
			endcase
		end
	end

	// Tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_code_q   <= KEY_NONE;
			cand_age_q    <= '0;
			stable_code_q <= KEY_NONE;
			held_code_q   <= KEY_NONE;
			hold_age_q    <= '0;
			hold_done_q   <= 1'b0;
		end else if (step) begin
			cand_code_q   <= cand_code_d;
			cand_age_q    <= cand_age_d;
			stable_code_q <= stable_code_d;
			held_code_q   <= held_code_d;
			hold_age_q    <= hold_age_d;
			hold_done_q   <= hold_done_d;
		end
	end

endmodule

/* dv/tb_keypad_debounce_press_hold_core.sv */
// Self-checking testbench for keypad_debounce_press_hold_core: queue-style stimulus, random idling
// on both sides and a scoreboard that predicts the PRESS and HOLD events of each tick.
// Depends on kdph_pkg and the design files; needs nothing else.
module tb_keypad_debounce_press_hold_core;
	timeunit 1ns;
	timeprecision 1ps;

	import kdph_pkg::*;

	localparam int SETTLE_CYCLES   = 8;
	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_OFF_CYCLES = 400;

	// Predicts the events of the block and checks them in order of arrival.
	class key_event_board;
		typedef struct packed {
			event_kind_t kind;
			key_char_t   ch;
		} key_event_t;

		key_event_t  expected[$];
		int unsigned mismatches = 0;

		ms_count_t   debounce_ticks = DEBOUNCE_RESET;
		ms_count_t   hold_ticks     = HOLD_RESET;

		key_code_t   cand_code      = KEY_NONE;
		ms_count_t   cand_age       = '0;
		key_code_t   debounced_code = KEY_NONE;
		key_code_t   tracked_code   = KEY_NONE;
		ms_count_t   track_age      = '0;
		bit          hold_reported  = 1'b0;

		function void set_reg(reg_index_t idx, ms_count_t v);
			if (idx == REG_DEBOUNCE_MS) begin
				debounce_ticks = v;
			end else begin
				hold_ticks = v;
			end
		endfunction

		// Counters stop at the top value so that long waits still compare as elapsed.
		function ms_count_t bump(ms_count_t v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		// The first key down in row-major order wins.
		function key_code_t first_key(logic [MASK_W-1:0] mask);
			key_code_t code;
			code = KEY_NONE;
			for (int i = 0; i < MASK_W; i++) begin
				if (mask[i] && code == KEY_NONE) begin
					code = key_code_t'(i + 1);
				end
			end
			return code;
		endfunction

		function key_char_t legend_of(key_code_t code);
			string legend;
			legend = "123456789*0#";
			return key_char_t'(legend[code - 1]);
		endfunction

		// One accepted tick: advance the debounce and hold tracking.
		function void note_tick(logic [MASK_W-1:0] mask);
			key_code_t raw;
			key_event_t ev;
			raw = first_key(mask);
			if (tracked_code != KEY_NONE) begin
				track_age = bump(track_age);
			end
			if (raw != cand_code) begin
				cand_code = raw;
				cand_age  = '0;
			end else begin
				cand_age = bump(cand_age);
			end
			if (cand_age >= debounce_ticks && debounced_code != cand_code) begin
				debounced_code = cand_code;
				if (debounced_code != KEY_NONE) begin
					// A new key, also straight from another one, restarts tracking.
					tracked_code  = debounced_code;
					track_age     = '0;
					hold_reported = 1'b0;
				end else begin
					// Release: PRESS only if no HOLD went out for this press.
					if (tracked_code != KEY_NONE && !hold_reported) begin
						ev.kind = EV_PRESS;
						ev.ch   = legend_of(tracked_code);
						expected.push_back(ev);
					end
					tracked_code = KEY_NONE;
				end
			end
			if (tracked_code != KEY_NONE && !hold_reported && track_age >= hold_ticks) begin
				ev.kind = EV_HOLD;
				ev.ch   = legend_of(tracked_code);
				expected.push_back(ev);
				hold_reported = 1'b1;
			end
		endfunction

		function void check_event(event_kind_t kind, key_char_t ch);
			key_event_t ev;
			if (expected.size() == 0) begin
				$error("unexpected event: event_kind %0d key_char 0x%0h", kind, ch);
				mismatches++;
			end else begin
				ev = expected.pop_front();
				if (kind != ev.kind) begin
					$error("event_kind: expected %0d, got %0d", ev.kind, kind);
					mismatches++;
				end
				if (ch != ev.ch) begin
					$error("key_char: expected 0x%0h, got 0x%0h", ev.ch, ch);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_wen      = 1'b0;
	reg_index_t            cfg_idx      = REG_DEBOUNCE_MS;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  push         = 1'b0;
	logic                  full;
	logic [MASK_W-1:0]     pressed_mask = '0;
	logic                  empty;
	logic                  pop          = 1'b0;
	event_kind_t           event_kind;
	key_char_t             key_char;

	key_event_board board = new();

	int unsigned ticks_sent    = 0;
	int unsigned stall_cycles  = 0;
	bit          steady_feed   = 1'b0;
	bit          hold_off_req  = 1'b0;

	keypad_debounce_press_hold_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.pressed_mask (pressed_mask),
		.empty        (empty),
		.pop          (pop),
		.event_kind   (event_kind),
		.key_char     (key_char)
	);

	always #1 clk = ~clk;

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (steady_feed || r < 70) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [MASK_W-1:0] noise_mask();
		return ($urandom_range(0, 2) == 0) ? 12'h000 : 12'($urandom);
	endfunction

	// Key k down, sometimes together with keys later in the scan order.
	function automatic logic [MASK_W-1:0] key_mask(int k);
		logic [MASK_W-1:0] above;
		above = 12'($urandom) & ~12'((2 << k) - 1);
		return ($urandom_range(0, 1) != 0) ? (12'(1 << k) | above) : 12'(1 << k);
	endfunction

	// Offer one tick and wait for its transfer.
	task automatic push_tick(input logic [MASK_W-1:0] m);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		pressed_mask <= m;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_tick(m);
		ticks_sent++;
	endtask

	// Let every expected event arrive, then give the pipeline time to empty.
	task automatic settle();
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers, one per cycle; only called while the block is idle.
	task automatic write_config(input ms_count_t deb, input ms_count_t hold);
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_DEBOUNCE_MS;
		cfg_wdata <= deb;
		@(posedge clk);
		cfg_idx   <= REG_HOLD_MS;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		board.set_reg(REG_DEBOUNCE_MS, deb);
		board.set_reg(REG_HOLD_MS, hold);
	endtask

	// One press from bounce to release, with broken variants now and then.
	task automatic run_press_cycle(input int deb, input int hold);
		int k;
		int n;
		int len;
		int r;
		steady_feed = ($urandom_range(0, 3) == 0);
		n = $urandom_range(0, deb + 2);
		repeat (n) push_tick(noise_mask());
		k = $urandom_range(0, 11);
		r = $urandom_range(0, 9);
		if (r < 2) begin
			len = $urandom_range(1, deb + 1);
		end else if (r < 6) begin
			len = deb + 1 + $urandom_range(0, hold);
		end else begin
			len = deb + hold + $urandom_range(0, 5);
		end
		repeat (len) push_tick(key_mask(k));
		// Straight change to another key without a release in between.
		if ($urandom_range(0, 5) == 0) begin
			k   = $urandom_range(0, 11);
			len = deb + 1 + $urandom_range(0, hold + 4);
			repeat (len) push_tick(key_mask(k));
		end
		n = $urandom_range(0, deb + 1);
		repeat (n) push_tick(($urandom_range(0, 1) != 0) ? key_mask(k) : 12'h000);
		if ($urandom_range(0, 4) == 0) begin
			len = $urandom_range(0, deb);
		end else begin
			len = deb + 1 + $urandom_range(0, 3);
		end
		repeat (len) push_tick(12'h000);
		steady_feed = 1'b0;
	endtask

	task automatic run_phase(input int deb, input int hold, input int unsigned budget);
		int unsigned start;
		write_config(ms_count_t'(deb), ms_count_t'(hold));
		start = ticks_sent;
		while (ticks_sent - start < budget) run_press_cycle(deb, hold);
		settle();
	endtask

	// Result side: random pop idling, steady stretches and one long hold-off.
	initial begin : result_side
		int idle_left   = 0;
		int steady_left = 0;
		int r           = 0;
		bit held_off    = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				board.check_event(event_kind, key_char);
			end
			if (hold_off_req && !held_off) begin
				// The sender keeps offering, so the queues fill and full rises.
				held_off = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (steady_left > 0) begin
				pop <= 1'b1;
				steady_left--;
			end else if (idle_left > 0) begin
				pop <= 1'b0;
				idle_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					pop <= 1'b1;
				end else if (r < 90) begin
					pop <= 1'b0;
					idle_left = $urandom_range(0, 3);
				end else if (r < 95) begin
					pop <= 1'b1;
					steady_left = $urandom_range(30, 60);
				end else begin
					pop <= 1'b0;
					idle_left = $urandom_range(10, 40);
				end
			end
		end
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_wen) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Main sequence: reset, directed ticks, random phases, verdict.
	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero debounce, every key pressed for one tick and released.
		// The first press has all keys down, so only the first in scan order counts.
		write_config(16'd0, 16'd2);
		push_tick(12'hFFF);
		push_tick(12'h000);
		for (int k = 1; k < MASK_W; k++) begin
			push_tick(12'(1 << k));
			push_tick(12'h000);
		end
		settle();

		// Zero debounce and zero hold time, with the long result hold-off.
		hold_off_req = 1'b1;
		run_phase(0, 0, 150);
		run_phase(1, 5, 200);
		run_phase(3, 12, 200);
		run_phase(2, 1, 100);
		run_phase(int'(DEBOUNCE_RESET), int'(HOLD_RESET), 250);

		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* keypad_debounce_press_hold_core.f */
design/kdph_pkg.sv
design/kdph_queue.sv
design/kdph_front.sv
design/kdph_back.sv
design/keypad_debounce_press_hold_core.sv
dv/tb_keypad_debounce_press_hold_core.sv
